// ===== hdl/avt_pkg.sv =====
package avt_pkg;

   localparam int DIV_W     = 32;
   localparam int DIVISOR_W = 16;
   localparam int STEP_W    = $clog2(DIV_W + 1);

   localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
   localparam logic [31:0] TPM_RESET  = 32'd31735537;

   localparam logic KIND_CAPTURE  = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_rsp_type;

endpackage

// ===== hdl/avt_ram.sv =====
module avt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/avt_divider.sv =====
module avt_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  avt_pkg::div_req_type            div_req,
   input  logic [avt_pkg::DIV_W-1:0]       dividend,
   input  logic [avt_pkg::DIVISOR_W-1:0]   divisor,
   output avt_pkg::div_rsp_type            div_rsp,
   output logic [avt_pkg::DIV_W-1:0]       quotient
);
   import avt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    count_ff, count_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W+1:0] diff;

   // one quotient bit per cycle, msb first
   always_comb begin
      shifted  = {rem_ff, num_ff[DIV_W-1]};
      diff     = {1'b0, shifted} - {2'b00, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = div_req.steps;
         num_in   = dividend;
         quo_in   = '0;
         rem_in   = '0;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         if (!diff[DIVISOR_W+1]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff - STEP_W'(1);
         if (count_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign quotient     = quo_ff;

endmodule

// ===== hdl/averaging_tachometer.sv =====
// channel   direction  ports                                   meaning
// req       in         req_valid req_ready req_kind req_period  capture or overflow event
// rsp       out        rsp_valid rsp_ready rsp_rpm rsp_saturated speed after each event
// csr       in         csr_valid csr_ready csr_data            ticks_per_minute write
//
// one event at a time; a capture reads and updates the store, then the bit-serial divider
// first forms the mean and then the quotient; an overflow skips the store update;
// the running total is TW = 16 + clog2(SAMPLE_COUNT) bits wide (19 for eight samples)
// reset is synchronous; the period store is marked empty through per-entry valid bits
// the next event is taken while a result still waits in the output register; the
// result after it then holds the block until the waiting one is taken by rsp_ready
module averaging_tachometer #(
   parameter int SAMPLE_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_period,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_rpm,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import avt_pkg::*;

   // width of the running total and of a store position
   localparam int TW = 16 + $clog2(SAMPLE_COUNT);
   localparam int SW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
   localparam logic [SW-1:0] SLOT_LAST = SW'(SAMPLE_COUNT - 1);
   localparam logic [TW-1:0] TOTAL_FULL = TW'(PERIOD_MAX * SAMPLE_COUNT);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_READ      = 7'b0000010,
      S_MEAN      = 7'b0000100,
      S_MEAN_WAIT = 7'b0001000,
      S_QUOT      = 7'b0010000,
      S_QUOT_WAIT = 7'b0100000,
      S_EMIT      = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       tpm_ff, tpm_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [TW-1:0]     total_ff, total_in;
   logic [SAMPLE_COUNT-1:0] valid_ff, valid_in;
   logic              fill_max_ff, fill_max_in;
   logic [15:0]       period_ff, period_in;
   logic [15:0]       mean_ff, mean_in;
   logic [15:0]       res_rpm_ff, res_rpm_in;
   logic              res_sat_ff, res_sat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_rpm_ff, rsp_rpm_in;
   logic              rsp_sat_ff, rsp_sat_in;

   logic              req_take;
   logic              ram_wr_en;
   logic [15:0]       ram_rd_data;
   logic [15:0]       old_period;
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   logic [DIV_W-1:0]  div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [DIV_W-1:0]  div_quotient;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // period store, read at the write position whenever an event is accepted
   avt_ram #(
      .WIDTH(16),
      .DEPTH(SAMPLE_COUNT)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (period_ff),
      .rd_en   (req_take),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign ram_wr_en = (state_ff == S_READ);

   // an entry not written since reset or overflow reads as the fill value
   assign old_period = valid_ff[slot_ff] ? ram_rd_data : {16{fill_max_ff}};

   // shared serial divider: mean first, quotient second
   avt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_rsp  (div_rsp),
      .quotient (div_quotient)
   );

   always_comb begin
      div_req.start = 1'b0;
      div_req.steps = STEP_W'(TW);
      div_dividend  = DIV_W'(total_ff) << (DIV_W - TW);
      div_divisor   = DIVISOR_W'(SAMPLE_COUNT);
      if (state_ff == S_QUOT) begin
         div_req.start = 1'b1;
         div_req.steps = STEP_W'(DIV_W);
         div_dividend  = tpm_ff;
         div_divisor   = mean_ff;
      end else if (state_ff == S_MEAN) begin
         div_req.start = (total_ff != '0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      tpm_in       = tpm_ff;
      slot_in      = slot_ff;
      total_in     = total_ff;
      valid_in     = valid_ff;
      fill_max_in  = fill_max_ff;
      period_in    = period_ff;
      mean_in      = mean_ff;
      res_rpm_in   = res_rpm_ff;
      res_sat_in   = res_sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_valid && csr_ready) begin
         tpm_in = csr_data;
      end

      // output register drains independently of the event in progress
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               period_in = req_period;
               if (req_kind == KIND_OVERFLOW) begin
                  // every entry becomes the longest period, position kept
                  valid_in    = '0;
                  fill_max_in = 1'b1;
                  total_in    = TOTAL_FULL;
                  state_in    = S_MEAN;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // swap the oldest period for the new one in the running total
            total_in          = total_ff - TW'(old_period) + TW'(period_ff);
            valid_in[slot_ff] = 1'b1;
            slot_in           = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SW'(1);
            state_in          = S_MEAN;
         end
         S_MEAN: begin
            if (total_ff == '0) begin
               // zero total: empty store or all periods zero
               res_rpm_in = '0;
               res_sat_in = 1'b0;
               state_in   = S_EMIT;
            end else begin
               state_in = S_MEAN_WAIT;
            end
         end
         S_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in = div_quotient[15:0];
               if (div_quotient[15:0] == '0) begin
                  // mean truncates to zero, no division
                  res_rpm_in = '0;
                  res_sat_in = 1'b0;
                  state_in   = S_EMIT;
               end else begin
                  state_in = S_QUOT;
               end
            end
         end
         S_QUOT: begin
            state_in = S_QUOT_WAIT;
         end
         S_QUOT_WAIT: begin
            if (div_rsp.done) begin
               // clip quotients above sixteen bits
               res_sat_in = |div_quotient[DIV_W-1:16];
               res_rpm_in = res_sat_in ? PERIOD_MAX : div_quotient[15:0];
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_rpm_in   = res_rpm_ff;
               rsp_sat_in   = res_sat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tpm_ff       <= TPM_RESET;
         slot_ff      <= '0;
         total_ff     <= '0;
         valid_ff     <= '0;
         fill_max_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tpm_ff       <= tpm_in;
         slot_ff      <= slot_in;
         total_ff     <= total_in;
         valid_ff     <= valid_in;
         fill_max_ff  <= fill_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      period_ff  <= period_in;
      mean_ff    <= mean_in;
      res_rpm_ff <= res_rpm_in;
      res_sat_ff <= res_sat_in;
      rsp_rpm_ff <= rsp_rpm_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rpm       = rsp_rpm_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ===== bench/averaging_tachometer_test.sv =====
module averaging_tachometer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import avt_pkg::*;

   localparam int SAMPLES       = 8;
   localparam int STALL_LIMIT   = 4000;   // cycles with no transaction on any channel
   localparam int SETTLE_CYCLES = 100;    // a little beyond one event's latency
   localparam int PHASE_EVENTS  = 275;

   // idle percentages per traffic scheme: sender, receiver
   localparam int SEND_IDLE [3] = '{16, 81, 0};
   localparam int RECV_IDLE [3] = '{81, 16, 0};

   typedef struct packed {
      logic        kind;
      logic [15:0] period;
   } pulse_item_type;

   typedef struct packed {
      logic [15:0] rpm;
      logic        saturated;
   } speed_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic        req_kind      = 1'b0;
   logic [15:0] req_period    = '0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [15:0] rsp_rpm;
   logic        rsp_saturated;
   logic        csr_valid     = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data      = '0;

   // events waiting to be driven, speeds waiting to come out
   pulse_item_type pending_items [$];
   speed_type      expected_speeds [$];

   // predicted block state
   logic [15:0] period_hist [SAMPLES];
   logic [2:0]  fill_pos;
   logic [18:0] period_sum;
   logic [31:0] ticks_per_min;

   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             mismatches    = 0;
   int             stall_cycles  = 0;
   pulse_item_type next_item;
   speed_type      wanted;

   averaging_tachometer #(
      .SAMPLE_COUNT(SAMPLES)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_period   (req_period),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_rpm      (rsp_rpm),
      .rsp_saturated(rsp_saturated),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data)
   );

   always #2 clock = ~clock;

   // update the period store with one event and derive the speed that follows
   function automatic speed_type speed_after_event(logic kind, logic [15:0] period);
      speed_type   res;
      logic [31:0] mean;
      logic [31:0] quotient;
      res.rpm       = '0;
      res.saturated = 1'b0;
      if (kind == KIND_CAPTURE) begin
         // replace the oldest entry, running sum follows
         period_sum            = period_sum - period_hist[fill_pos] + period;
         period_hist[fill_pos] = period;
         fill_pos              = (fill_pos == 3'(SAMPLES - 1)) ? 3'd0 : fill_pos + 3'd1;
      end else begin
         // timer overflow: every entry to the longest period, write position kept
         for (int i = 0; i < SAMPLES; i++)
            period_hist[i] = PERIOD_MAX;
         period_sum = 19'(SAMPLES * 32'(PERIOD_MAX));
      end
      mean = 32'(period_sum) / 32'(SAMPLES);
      // empty store and zero mean both leave a speed of zero
      if (mean != 0) begin
         quotient = ticks_per_min / mean;
         if (quotient > 32'(PERIOD_MAX)) begin
            res.rpm       = PERIOD_MAX;
            res.saturated = 1'b1;
         end else begin
            res.rpm = quotient[15:0];
         end
      end
      return res;
   endfunction

   function automatic void push_item(logic kind, logic [15:0] period);
      pulse_item_type item;
      item.kind   = kind;
      item.period = period;
      pending_items.push_back(item);
   endfunction

   // mostly plain captures of varied magnitude, with overflows and runs of
   // tiny periods that pull the mean down to zero
   task automatic queue_random_event();
      int          pick;
      logic [15:0] bits;
      pick = $urandom_range(0, 99);
      bits = 16'($urandom);
      if (pick < 5) begin
         push_item(KIND_OVERFLOW, bits);
      end else if (pick < 8) begin
         repeat (SAMPLES) push_item(KIND_CAPTURE, 16'($urandom_range(0, 1)));
      end else if (pick < 18) begin
         push_item(KIND_CAPTURE, 16'($urandom_range(0, 15)));
      end else if (pick < 23) begin
         push_item(KIND_CAPTURE, PERIOD_MAX);
      end else begin
         push_item(KIND_CAPTURE, bits >> $urandom_range(0, 15));
      end
   endtask

   // wait until every event went in and every speed came back
   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_speeds.size() != 0);
   endtask

   // ticks-per-minute register write, only while the block is idle
   task automatic write_ticks(input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      ticks_per_min = value;
      csr_valid <= 1'b0;
      csr_data  <= $urandom();
   endtask

   // event driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_speeds.push_back(speed_after_event(req_kind, req_period));
         end
         // slot is free unless a transaction is still held
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               req_valid  <= 1'b1;
               req_kind   <= next_item.kind;
               req_period <= next_item.period;
            end else begin
               req_valid  <= 1'b0;
               req_kind   <= 1'($urandom);
               req_period <= 16'($urandom);
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_speeds.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual rpm %0d saturated %0d",
                        $time, rsp_rpm, rsp_saturated);
               mismatches++;
            end else begin
               wanted = expected_speeds.pop_front();
               if (rsp_rpm !== wanted.rpm) begin
                  $display("%0t: rpm expected %0d actual %0d", $time, wanted.rpm, rsp_rpm);
                  mismatches++;
               end
               if (rsp_saturated !== wanted.saturated) begin
                  $display("%0t: saturated expected %0d actual %0d",
                           $time, wanted.saturated, rsp_saturated);
                  mismatches++;
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog: any transaction on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] ticks_table [6];

      // extremes first, then random and nominal settings
      ticks_table[0] = 32'hFFFF_FFFF;
      ticks_table[1] = 32'd1;
      ticks_table[2] = $urandom();
      ticks_table[3] = TPM_RESET;
      ticks_table[4] = $urandom_range(100000, 50000000);
      ticks_table[5] = $urandom();

      for (int i = 0; i < SAMPLES; i++)
         period_hist[i] = '0;
      fill_pos      = '0;
      period_sum    = '0;
      ticks_per_min = TPM_RESET;
      send_idle_pct = SEND_IDLE[0];
      recv_idle_pct = RECV_IDLE[0];

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed events at the reset register value
      push_item(KIND_CAPTURE, 16'd0);        // store still empty
      push_item(KIND_CAPTURE, 16'd1);        // nonzero sum, zero mean
      push_item(KIND_CAPTURE, 16'd7);        // mean of one, quotient clipped
      push_item(KIND_CAPTURE, PERIOD_MAX);
      push_item(KIND_OVERFLOW, PERIOD_MAX);  // period field ignored on overflow
      push_item(KIND_OVERFLOW, 16'd0);
      push_item(KIND_CAPTURE, 16'd0);        // write position survived the overflow
      repeat (SAMPLES) push_item(KIND_CAPTURE, 16'd100);
      repeat (SAMPLES) push_item(KIND_CAPTURE, 16'd0);  // back to an empty sum
      drain();

      // random phases: each a new register value, idling scheme every two phases
      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = SEND_IDLE[phase / 2];
         recv_idle_pct = RECV_IDLE[phase / 2];
         write_ticks(ticks_table[phase]);
         @(negedge clock);
         repeat (PHASE_EVENTS) queue_random_event();
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_speeds.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/avt_pkg.sv
hdl/avt_ram.sv
hdl/avt_divider.sv
hdl/averaging_tachometer.sv
bench/averaging_tachometer_test.sv
